// ===== src/ecr_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
package ecr_pkg;

    // Defaults for the top-level parameters
    localparam int COUNT_WIDTH_DEF = 14;
    localparam int SCALE_Q16_DEF   = 11261;

    // Field widths fixed by the register map and result format
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int TIME_W     = 14;
    localparam int TRIG_W     = 4;
    localparam int COMP_W     = 10;
    localparam int DIST_W     = 12;
    localparam int STAT_W     = 2;
    localparam int FRAC_W     = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd4;

    // Register reset values
    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 14'd12000;
    localparam logic [TIME_W-1:0] MIN_PULS_RST = 14'd100;
    localparam logic [TRIG_W-1:0] TRIG_LEN_RST = 4'd10;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 12'd2000;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_MEAS = 2'd2
    } t_phase;

    typedef struct packed {
        logic        [TIME_W-1:0] timeout;
        logic        [TIME_W-1:0] min_pulse;
        logic        [TRIG_W-1:0] trig_len;
        logic signed [COMP_W-1:0] comp;
        logic        [DIST_W-1:0] max_dist;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] dist_mm;
        logic [STAT_W-1:0] status;
    } t_dist_res;

    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] dist_mm;
        logic [STAT_W-1:0] status;
    } t_step_res;

endpackage

// ===== src/ecr_cfg_regs.sv =====
// Configuration register file of the echo ranger.
module ecr_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ecr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ecr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ecr_pkg::t_cfg                   o_cfg
);

    ecr_pkg::t_cfg r_cfg;

    // Register writes, one register per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout   <= ecr_pkg::TIMEOUT_RST;
            r_cfg.min_pulse <= ecr_pkg::MIN_PULS_RST;
            r_cfg.trig_len  <= ecr_pkg::TRIG_LEN_RST;
            r_cfg.comp      <= '0;
            r_cfg.max_dist  <= ecr_pkg::MAX_DIST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ecr_pkg::CFG_TIMEOUT:  r_cfg.timeout   <= i_cfg_data[ecr_pkg::TIME_W-1:0];
                ecr_pkg::CFG_MIN_PULS: r_cfg.min_pulse <= i_cfg_data[ecr_pkg::TIME_W-1:0];
                ecr_pkg::CFG_TRIG_LEN: r_cfg.trig_len  <= i_cfg_data[ecr_pkg::TRIG_W-1:0];
                ecr_pkg::CFG_COMP:     r_cfg.comp      <= i_cfg_data[ecr_pkg::COMP_W-1:0];
                ecr_pkg::CFG_MAX_DIST: r_cfg.max_dist  <= i_cfg_data[ecr_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/ecr_dist_calc.sv =====
// Pulse range check and pulse-to-millimeter conversion with clamp.
module ecr_dist_calc #(
    parameter int COUNT_WIDTH = ecr_pkg::COUNT_WIDTH_DEF,
    parameter int SCALE_Q16   = ecr_pkg::SCALE_Q16_DEF
) (
    input  logic [COUNT_WIDTH-1:0] i_pulse,
    input  ecr_pkg::t_cfg          i_cfg,
    output ecr_pkg::t_dist_res     o_res
);

    localparam int PROD_W = COUNT_WIDTH + ecr_pkg::FRAC_W;
    localparam int WIDE_W = (COUNT_WIDTH > ecr_pkg::DIST_W) ? COUNT_WIDTH : ecr_pkg::DIST_W;
    localparam int SUM_W  = WIDE_W + 2;
    localparam int CMP_W  = (COUNT_WIDTH > ecr_pkg::TIME_W) ? COUNT_WIDTH : ecr_pkg::TIME_W;

    logic [PROD_W-1:0]      w_prod;
    logic [COUNT_WIDTH-1:0] w_scaled;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_max;
    logic                   w_bad;

    // Pulse outside min..timeout window
    assign w_bad = (CMP_W'(i_pulse) > CMP_W'(i_cfg.timeout)) ||
                   (CMP_W'(i_pulse) < CMP_W'(i_cfg.min_pulse));

    // Q16 scale, then mounting offset
    assign w_prod   = PROD_W'(i_pulse) * PROD_W'(SCALE_Q16);
    assign w_scaled = w_prod[PROD_W-1:ecr_pkg::FRAC_W];
    assign w_sum    = signed'(SUM_W'(w_scaled)) + SUM_W'(i_cfg.comp);
    assign w_max    = signed'(SUM_W'(i_cfg.max_dist));

    // Saturate to 0..max, or report max on a bad pulse
    always_comb begin
        if (w_bad) begin
            o_res.dist_mm = i_cfg.max_dist;
            o_res.status  = ecr_pkg::ST_RANGE;
        end else begin
            o_res.status = ecr_pkg::ST_OK;
            if (w_sum < 0) begin
                o_res.dist_mm = '0;
            end else if (w_sum > w_max) begin
                o_res.dist_mm = i_cfg.max_dist;
            end else begin
                o_res.dist_mm = w_sum[ecr_pkg::DIST_W-1:0];
            end
        end
    end

endmodule

// ===== src/ecr_seq.sv =====
// Measurement sequencer: trigger, tick counting, edge capture, result store.
module ecr_seq #(
    parameter int COUNT_WIDTH = ecr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic                   i_start,
    input  logic                   i_echo,
    input  ecr_pkg::t_cfg          i_cfg,
    output logic [COUNT_WIDTH-1:0] o_pulse,
    input  ecr_pkg::t_dist_res     i_dist,
    output ecr_pkg::t_step_res     o_res
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam int CMP_W = (COUNT_WIDTH > ecr_pkg::TIME_W) ? COUNT_WIDTH : ecr_pkg::TIME_W;

    ecr_pkg::t_phase              r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]       r_elapsed, n_elapsed;
    logic [COUNT_WIDTH-1:0]       r_rise, n_rise;
    logic                         r_echo_prev;
    logic [ecr_pkg::DIST_W-1:0]   r_last_dist, n_last_dist;
    logic [ecr_pkg::STAT_W-1:0]   r_last_stat, n_last_stat;

    logic [COUNT_WIDTH-1:0]    w_cnt_inc;
    logic [COUNT_WIDTH-1:0]    w_len;
    logic                      w_rise, w_fall, w_tmo, w_trig_end, w_start_end;
    logic                      w_trig, w_done;

    // Shared tick decode
    assign w_cnt_inc   = (r_elapsed < CNT_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign w_len       = (i_cfg.trig_len == '0) ? COUNT_WIDTH'(1)
                                                : COUNT_WIDTH'(i_cfg.trig_len);
    assign w_rise      = i_echo && !r_echo_prev;
    assign w_fall      = !i_echo && r_echo_prev;
    assign w_tmo       = (CMP_W'(w_cnt_inc) > CMP_W'(i_cfg.timeout)) || (w_cnt_inc == CNT_MAX);
    assign w_trig_end  = (w_cnt_inc >= w_len);
    assign w_start_end = (w_len == COUNT_WIDTH'(1));
    assign o_pulse     = (w_cnt_inc >= r_rise) ? w_cnt_inc - r_rise : '0;

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_rise    = r_rise;
        unique case (r_phase)
            ecr_pkg::PH_TRIG: begin
                if (w_trig_end) begin
                    n_phase   = ecr_pkg::PH_MEAS;
                    n_elapsed = '0;
                    n_rise    = '0;
                end else begin
                    n_elapsed = w_cnt_inc;
                end
            end
            ecr_pkg::PH_MEAS: begin
                n_elapsed = w_cnt_inc;
                if (w_rise) begin
                    n_rise = w_cnt_inc;
                end
                if (w_fall || w_tmo) begin
                    n_phase = ecr_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = ecr_pkg::PH_IDLE;
                if (i_start) begin
                    if (w_start_end) begin
                        n_phase   = ecr_pkg::PH_MEAS;
                        n_elapsed = '0;
                        n_rise    = '0;
                    end else begin
                        n_phase   = ecr_pkg::PH_TRIG;
                        n_elapsed = COUNT_WIDTH'(1);
                    end
                end
            end
        endcase
    end

    // Outputs and result store
    always_comb begin
        w_trig      = 1'b0;
        w_done      = 1'b0;
        n_last_dist = r_last_dist;
        n_last_stat = r_last_stat;
        unique case (r_phase)
            ecr_pkg::PH_TRIG: begin
                w_trig = 1'b1;
            end
            ecr_pkg::PH_MEAS: begin
                if (w_fall) begin
                    w_done      = 1'b1;
                    n_last_dist = i_dist.dist_mm;
                    n_last_stat = i_dist.status;
                end else if (w_tmo) begin
                    w_done      = 1'b1;
                    n_last_dist = i_cfg.max_dist;
                    n_last_stat = ecr_pkg::ST_TIMEOUT;
                end
            end
            default: begin
                w_trig = i_start;
            end
        endcase
    end

    always_comb begin
        o_res.trigger = w_trig;
        o_res.busy    = (n_phase != ecr_pkg::PH_IDLE);
        o_res.done    = w_done;
        o_res.dist_mm = n_last_dist;
        o_res.status  = n_last_stat;
    end

    // State update, one step per input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ecr_pkg::PH_IDLE;
            r_elapsed   <= '0;
            r_rise      <= '0;
            r_echo_prev <= 1'b0;
            r_last_dist <= '0;
            r_last_stat <= ecr_pkg::ST_OK;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_rise      <= n_rise;
            r_echo_prev <= i_echo;
            r_last_dist <= n_last_dist;
            r_last_stat <= n_last_stat;
        end
    end

    // Checks
    a_trig_only_from_idle_or_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == ecr_pkg::PH_MEAS) |-> !w_trig)
        else $error("trigger driven while measuring");

    a_done_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_done) |=> (r_phase == ecr_pkg::PH_IDLE))
        else $error("sequencer not idle after a result");

    a_meas_entry_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == ecr_pkg::PH_TRIG && w_trig_end) |=>
            (r_phase == ecr_pkg::PH_MEAS && r_elapsed == '0 && r_rise == '0))
        else $error("measurement did not start from a cleared count");

endmodule

// ===== src/ultrasonic_echo_ranger_core.sv =====
// Top level of the ultrasonic echo ranger: handshake, pipeline registers, wiring.
//
// Usage: each input beat is one microsecond tick carrying start_req and the
// sampled echo_level. Every input beat yields exactly one result beat with the
// trigger level, busy and done flags and the latest stored distance and status.
// The input channel is i_valid / o_stall, the result channel o_valid / i_stall.
// A beat is taken at a clock edge with valid high and stall low.
// A beat is captured in the input register and then, when the result register is
// free or the receiver does not stall, stepped through the sequencer and distance
// logic into the result register. Throughput: one beat per cycle while the
// receiver does not stall, limited by the single step of the sequencer.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more beat, and o_stall rises only while both are
// full and i_stall is high.
// Reset (synchronous, active low) empties both registers, loads the register
// defaults and returns the sequencer to idle with zero distance and status ok.
// Configuration must be written via i_cfg_we / i_cfg_idx / i_cfg_data only while idle; the block does not enforce it.
module ultrasonic_echo_ranger_core #(
    parameter int COUNT_WIDTH = ecr_pkg::COUNT_WIDTH_DEF,
    parameter int SCALE_Q16   = ecr_pkg::SCALE_Q16_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ecr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ecr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_start_req,
    input  logic                            i_echo_level,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_trigger,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic [ecr_pkg::DIST_W-1:0]      o_distance_mm,
    output logic [ecr_pkg::STAT_W-1:0]      o_status
);

    ecr_pkg::t_cfg          w_cfg;
    ecr_pkg::t_dist_res     w_dist;
    ecr_pkg::t_step_res     w_res;
    ecr_pkg::t_step_res     r_res;
    logic [COUNT_WIDTH-1:0] w_pulse;

    logic r_in_valid;
    logic r_start;
    logic r_echo;
    logic r_out_valid;
    logic w_adv;

    // Pipeline control
    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_start <= i_start_req;
            r_echo  <= i_echo_level;
        end
    end

    ecr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ecr_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_start (r_start),
        .i_echo  (r_echo),
        .i_cfg   (w_cfg),
        .o_pulse (w_pulse),
        .i_dist  (w_dist),
        .o_res   (w_res)
    );

    ecr_dist_calc #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .SCALE_Q16   (SCALE_Q16)
    ) u_dist (
        .i_pulse (w_pulse),
        .i_cfg   (w_cfg),
        .o_res   (w_dist)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_trigger     = r_res.trigger;
    assign o_busy_res    = r_res.busy;
    assign o_done_res    = r_res.done;
    assign o_distance_mm = r_res.dist_mm;
    assign o_status      = r_res.status;

    // Checks
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_busy_res)
        else $error("busy reported on the done beat");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_trigger) |-> o_busy_res)
        else $error("trigger driven while not busy");

    a_err_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res && o_status != ecr_pkg::ST_OK) |->
            (o_distance_mm == w_cfg.max_dist))
        else $error("error result without max distance");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_stall) |=> r_in_valid)
        else $error("stalled input beat dropped");

endmodule
